// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define CFB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cfb assertion failed");

// clocked assertion that also holds across reset
`define CFB_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("cfb assertion failed");

`endif

// File: rtl/core/cfb_pkg.sv
// types, constants and functions of the command frame builder
package cfb_pkg;

   // command word as it arrives
   typedef struct packed {
      logic [7:0]  component_number;
      logic [31:0] value_bits;
   } req_word_type;

   // one frame byte as it leaves
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_last;
   } rsp_word_type;

   // handover from the command register to the frame engine
   typedef struct packed {
      logic         valid;
      req_word_type word;
   } cmd_hand_type;

   localparam int unsigned POS_W = 4;

   // byte positions within a frame
   localparam logic [POS_W-1:0] POS_START  = 4'd0;
   localparam logic [POS_W-1:0] POS_CNT_LO = 4'd1;
   localparam logic [POS_W-1:0] POS_CNT_HI = 4'd2;
   localparam logic [POS_W-1:0] POS_COMP   = 4'd3;
   localparam logic [POS_W-1:0] POS_VAL_0  = 4'd4;
   localparam logic [POS_W-1:0] POS_VAL_1  = 4'd5;
   localparam logic [POS_W-1:0] POS_VAL_2  = 4'd6;
   localparam logic [POS_W-1:0] POS_VAL_3  = 4'd7;
   localparam logic [POS_W-1:0] POS_CRC_LO = 4'd8;
   localparam logic [POS_W-1:0] POS_CRC_HI = 4'd9;

   localparam logic [7:0]  FRAME_START = 8'hAA;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'h8408;

   // reflected crc-16 over one byte, lsb first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // byte of the frame at a given position
   function automatic logic [7:0] frame_byte_sel(
      input logic [POS_W-1:0] pos,
      input req_word_type     word,
      input logic [15:0]      counter,
      input logic [15:0]      crc
   );
      logic [7:0] b;
      case (pos)
         POS_START:  b = FRAME_START;
         POS_CNT_LO: b = counter[7:0];
         POS_CNT_HI: b = counter[15:8];
         POS_COMP:   b = word.component_number;
         POS_VAL_0:  b = word.value_bits[7:0];
         POS_VAL_1:  b = word.value_bits[15:8];
         POS_VAL_2:  b = word.value_bits[23:16];
         POS_VAL_3:  b = word.value_bits[31:24];
         POS_CRC_LO: b = crc[7:0];
         POS_CRC_HI: b = crc[15:8];
         default:    b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// File: rtl/core/command_frame_builder_crc16.sv
// top level of the command frame builder with crc-16 trailer
//
// req channel: one word carries a component number and 32 raw value bits.
// rsp channel: ten words per command, one frame byte each, frame_last on
// the tenth (crc high byte). Frame: 0xAA, packet counter (lsb first),
// component number, value bits (lsb first), crc-16 (lsb first).
// A command passes through the input register, is loaded into the sequencer
// state, and each frame byte is registered in the output register before it
// appears on rsp. The byte sequencer sends one frame byte per cycle through
// the output register while rsp is not stalled; a waiting command sits in the
// input register so frames follow without a gap.
// Reset clears the packet counter to 0, empties both registers and
// loads the crc with 0xFFFF.
// When rsp_stall is high a valid output word holds and, once the output register is full, the sequencer pauses;
// once the input register is full, req_stall goes high until it drains.
module command_frame_builder_crc16 (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cfb_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cfb_pkg::rsp_word_type rsp_data
);

   cfb_pkg::cmd_hand_type cmd;
   logic                  cmd_take;

   // input register
   cfb_cmd_buf u_cmd_buf (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   // frame engine and output register
   cfb_frame_gen u_frame_gen (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/core/cfb_cmd_buf.sv
// input register holding one command until the frame engine takes it
module cfb_cmd_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cfb_pkg::req_word_type req_data,
   output cfb_pkg::cmd_hand_type cmd,
   input  logic                  cmd_take
);

   logic                  full_ff;
   logic                  full_in;
   cfb_pkg::req_word_type word_ff;
   cfb_pkg::req_word_type word_in;
   logic                  accept;

   // take a word whenever the register is empty
   always_comb begin
      accept  = req_valid && !full_ff;
      full_in = full_ff;
      word_in = word_ff;
      if (accept) begin
         full_in = 1'b1;
         word_in = req_data;
      end else if (cmd_take) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign req_stall  = full_ff;
   assign cmd.valid  = full_ff;
   assign cmd.word   = word_ff;

endmodule

// File: rtl/core/cfb_frame_gen.sv
// frame engine: byte sequencer, running crc, packet counter and output register
module cfb_frame_gen (
   input  logic                  clock,
   input  logic                  reset,
   input  cfb_pkg::cmd_hand_type cmd,
   output logic                  cmd_take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cfb_pkg::rsp_word_type rsp_data
);

   logic                          active_ff, active_in;
   logic [cfb_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [15:0]                   crc_ff, crc_in;
   logic [15:0]                   counter_ff, counter_in;
   cfb_pkg::req_word_type         word_ff, word_in;
   logic                          out_valid_ff, out_valid_in;
   cfb_pkg::rsp_word_type         out_data_ff, out_data_in;
   logic                          advance;
   logic                          finish;
   logic                          load;
   logic [7:0]                    cur_byte;

   // step one byte whenever a frame is active and the output register is free or being emptied
   always_comb begin
      advance  = active_ff && (!out_valid_ff || !rsp_stall);
      finish   = advance && (pos_ff == cfb_pkg::POS_CRC_HI);
      load     = cmd.valid && (!active_ff || finish);
      cur_byte = cfb_pkg::frame_byte_sel(pos_ff, word_ff, counter_ff, crc_ff);

      active_in    = active_ff;
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      counter_in   = counter_ff;
      word_in      = word_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      // output register
      if (advance) begin
         out_valid_in           = 1'b1;
         out_data_in.frame_byte = cur_byte;
         out_data_in.frame_last = (pos_ff == cfb_pkg::POS_CRC_HI);
         pos_in                 = pos_ff + 1'b1;
         if (pos_ff < cfb_pkg::POS_CRC_LO) begin
            crc_in = cfb_pkg::crc_feed(crc_ff, cur_byte);
         end
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      // end of frame: counter moves on
      if (finish) begin
         active_in  = 1'b0;
         counter_in = counter_ff + 1'b1;
      end

      // start of the next frame
      if (load) begin
         active_in = 1'b1;
         pos_in    = cfb_pkg::POS_START;
         crc_in    = cfb_pkg::CRC_INIT;
         word_in   = cmd.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pos_ff       <= cfb_pkg::POS_START;
         crc_ff       <= cfb_pkg::CRC_INIT;
         counter_ff   <= 16'h0000;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         counter_ff   <= counter_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      out_data_ff <= out_data_in;
   end

   assign cmd_take  = load;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: rtl/core/cfb_checker.sv
// port-level checks of the command frame builder, bound to the top level
`include "assert_macros.svh"

module cfb_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input cfb_pkg::req_word_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input cfb_pkg::rsp_word_type rsp_data
);

   logic [cfb_pkg::POS_W-1:0] pos_ff;
   logic [cfb_pkg::POS_W-1:0] pos_in;
   logic                      rsp_take;
   logic                      at_first;
   logic                      at_tenth;
   logic                      start_byte;

   // position of the next byte seen on rsp
   always_comb begin
      rsp_take   = rsp_valid && !rsp_stall;
      at_first   = (pos_ff == cfb_pkg::POS_START);
      at_tenth   = (pos_ff == cfb_pkg::POS_CRC_HI);
      start_byte = (rsp_data.frame_byte == cfb_pkg::FRAME_START);
      pos_in     = pos_ff;
      if (rsp_take) begin
         if (rsp_data.frame_last) begin
            pos_in = cfb_pkg::POS_START;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= cfb_pkg::POS_START;
      end else begin
         pos_ff <= pos_in;
      end
   end

   `CFB_ASSERT(a_req_held, clock, reset, req_valid && req_stall |=> req_valid && $stable(req_data))
   `CFB_ASSERT(a_rsp_held, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
   `CFB_ASSERT(a_last_on_tenth, clock, reset, rsp_valid |-> (rsp_data.frame_last == at_tenth))
   `CFB_ASSERT(a_frame_starts, clock, reset, rsp_valid && at_first |-> start_byte)
   `CFB_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid)

endmodule

bind command_frame_builder_crc16 cfb_checker u_cfb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: verif/command_frame_builder_crc16_test.sv
// self-checking testbench for the command frame builder with crc-16 trailer
module command_frame_builder_crc16_test;

   localparam int          NUM_DIRECTED  = 16;
   localparam int          NUM_RANDOM    = 314;
   localparam int          CALM_TAIL     = 60;
   localparam int          HOLD_AT       = 120;
   localparam int          PAUSE_AT      = 170;
   localparam int          HOLD_CYCLES   = 80;
   localparam int          DRAIN_CYCLES  = 24;
   localparam int unsigned CYCLE_LIMIT   = 200000;

   // one row of the directed table; cnt is the counter typed in when known
   typedef struct packed {
      logic [7:0]  comp;
      logic [31:0] bits;
      logic        typed;
      logic [15:0] cnt;
   } cmd_row_type;

   localparam cmd_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{8'h00, 32'h00000000, 1'b1, 16'd0},  // first frame after reset, all zero
      '{8'hFF, 32'hFFFFFFFF, 1'b1, 16'd1},  // everything at its top
      '{8'h00, 32'hFFFFFFFF, 1'b1, 16'd2},
      '{8'hFF, 32'h00000000, 1'b1, 16'd3},
      '{8'hAA, 32'hAAAAAAAA, 1'b0, 16'd0},  // start byte pattern inside payload
      '{8'h55, 32'h55555555, 1'b0, 16'd0},
      '{8'h01, 32'h3F800000, 1'b0, 16'd0},  // 1.0
      '{8'h80, 32'h80000000, 1'b0, 16'd0},  // negative zero
      '{8'h7F, 32'h7F800000, 1'b0, 16'd0},  // positive infinity
      '{8'h10, 32'hFF800000, 1'b0, 16'd0},  // negative infinity
      '{8'h20, 32'h7FC00000, 1'b0, 16'd0},  // quiet nan
      '{8'h21, 32'h7F800001, 1'b0, 16'd0},  // signalling nan
      '{8'hFE, 32'hFFC00001, 1'b0, 16'd0},  // negative nan with payload
      '{8'h02, 32'h00000001, 1'b0, 16'd0},  // smallest denormal
      '{8'h03, 32'h807FFFFF, 1'b0, 16'd0},
      '{8'hC3, 32'h89ABCDEF, 1'b0, 16'd0}
   };

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   cfb_pkg::req_word_type req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   cfb_pkg::rsp_word_type rsp_data;

   // predictor state
   logic [15:0]           packet_count = 16'd0;
   logic [15:0]           frame_crc    = cfb_pkg::CRC_INIT;
   cfb_pkg::rsp_word_type frame_bytes_due [$];

   bit           req_gaps_on  = 1'b1;
   bit           rsp_gaps_on  = 1'b1;
   bit           hold_off_ask = 1'b0;
   int           error_count  = 0;
   int           words_sent   = 0;
   int           bytes_checked = 0;
   int unsigned  cycle_count  = 0;

   command_frame_builder_crc16 uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // reflected crc-16, one data bit at a time, lsb first
   function automatic logic [15:0] crc16_mcrf_byte(input logic [15:0] crc_in,
                                                   input logic [7:0]  data);
      logic [15:0] r;
      logic        fb;
      int          b;
      r = crc_in;
      for (b = 0; b < 8; b++) begin
         fb = r[0] ^ data[b];
         r  = r >> 1;
         if (fb) begin
            r = r ^ cfb_pkg::CRC_POLY;
         end
      end
      return r;
   endfunction

   // expected ten bytes of the frame for one command word
   function automatic void predict_frame(input cfb_pkg::req_word_type w,
                                         input logic [15:0]           cnt);
      logic [7:0]            fr [10];
      cfb_pkg::rsp_word_type e;
      int                    i;
      fr[0] = cfb_pkg::FRAME_START;
      fr[1] = cnt[7:0];
      fr[2] = cnt[15:8];
      fr[3] = w.component_number;
      fr[4] = w.value_bits[7:0];
      fr[5] = w.value_bits[15:8];
      fr[6] = w.value_bits[23:16];
      fr[7] = w.value_bits[31:24];
      frame_crc = cfb_pkg::CRC_INIT;
      for (i = 0; i < 8; i++) begin
         frame_crc = crc16_mcrf_byte(frame_crc, fr[i]);
      end
      fr[8] = frame_crc[7:0];
      fr[9] = frame_crc[15:8];
      for (i = 0; i < 10; i++) begin
         e.frame_byte = fr[i];
         e.frame_last = (i == 9);
         frame_bytes_due.insert(frame_bytes_due.size(), e);
      end
   endfunction

   // random command word, with some weight on the inf/nan and zero/denormal space
   function automatic cfb_pkg::req_word_type random_word();
      cfb_pkg::req_word_type w;
      w.component_number = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0: w.value_bits = {1'($urandom), 8'hFF, 23'($urandom)};
         1: w.value_bits = {1'($urandom), 8'h00, 23'($urandom)};
         default: w.value_bits = $urandom;
      endcase
      return w;
   endfunction

   // offer one word, with an optional idle burst first, until it is taken
   task automatic send_word(input cfb_pkg::req_word_type w, input bit typed,
                            input logic [15:0] cnt);
      bit taken;
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
      end
      predict_frame(w, typed ? cnt : packet_count);
      packet_count = packet_count + 16'd1;
      words_sent++;
   endtask

   // wait for every outstanding frame byte, polling the queue on the clock; the wait comes before the first check
   task automatic wait_frames_drained();
      do begin
         @(posedge clock);
      end while (frame_bytes_due.size() != 0);
   endtask

   function automatic void report_mismatch(input string field, input logic [7:0] due_val,
                                           input logic [7:0] got_val);
      error_count++;
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, field, due_val, got_val);
   endfunction

   // result word checker
   always @(posedge clock) begin
      cfb_pkg::rsp_word_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         bytes_checked++;
         if (frame_bytes_due.size() == 0) begin
            error_count++;
            $display("%0t: unexpected frame byte, expected none, got %02h last %0b",
                     $time, rsp_data.frame_byte, rsp_data.frame_last);
         end else begin
            due = frame_bytes_due.pop_front();
            if (rsp_data.frame_byte !== due.frame_byte) begin
               report_mismatch("frame_byte", due.frame_byte, rsp_data.frame_byte);
            end
            if (rsp_data.frame_last !== due.frame_last) begin
               report_mismatch("frame_last", 8'(due.frame_last), 8'(rsp_data.frame_last));
            end
         end
      end
   end

   // receiver back-pressure: random bursts, plus one long hold-off on request
   initial begin
      int held;
      forever begin
         @(posedge clock);
         if (hold_off_ask) begin
            hold_off_ask = 1'b0;
            rsp_stall <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) begin
               @(posedge clock);
            end
            rsp_stall <= 1'b0;
         end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d frame bytes outstanding", $time,
                  frame_bytes_due.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // stimulus
   initial begin
      cfb_pkg::req_word_type w;
      int                    n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (n = 0; n < NUM_DIRECTED; n++) begin
         w.component_number = DIRECTED_ROWS[n].comp;
         w.value_bits       = DIRECTED_ROWS[n].bits;
         send_word(w, DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].cnt);
      end

      // random words with idling on both sides, except in the calm tail
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      for (n = 0; n < NUM_RANDOM; n++) begin
         if (n == HOLD_AT) begin
            hold_off_ask = 1'b1;
         end
         if (n == PAUSE_AT) begin
            req_valid <= 1'b0;
            wait_frames_drained();
         end
         if (n == NUM_RANDOM - CALM_TAIL) begin
            req_gaps_on = 1'b0;
            rsp_gaps_on = 1'b0;
         end
         send_word(random_word(), 1'b0, 16'd0);
      end
      req_valid <= 1'b0;

      wait_frames_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d command words sent, %0d frame bytes checked",
               words_sent, bytes_checked);
      $display("directed extremes and float patterns, long receiver hold-off, sender pause");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
